FILE: rtl/core/pbcd_pkg.sv
// ----------------------------------------------------------------------------
// pbcd_pkg
// Types and constants shared by the pushbuffer command decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package pbcd_pkg;

  localparam int CHANNELS = 8;

  localparam int CHANNEL_W = 3;
  localparam int WORD_W = 32;
  localparam int INDEX_W = 11;
  localparam int SUBCH_W = 3;
  localparam int COUNT_W = 11;
  localparam int MADDR_W = 13;
  localparam int ERR_W = 3;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_BASE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_LIMIT = 1'd1;

  localparam logic [WORD_W-1:0] BUFFER_BASE_RESET = 32'h0000_0000;
  localparam logic [WORD_W-1:0] BUFFER_LIMIT_RESET = 32'h01FF_FFFF;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_DELIVER = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MEM = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NEST = 3'd2;
  localparam logic [ERR_W-1:0] ERR_RET = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CMD = 3'd4;

  localparam logic [WORD_W-1:0] OLD_JUMP_MASK = 32'hE000_0003;
  localparam logic [WORD_W-1:0] OLD_JUMP_CODE = 32'h2000_0000;
  localparam logic [WORD_W-1:0] OLD_JUMP_ADDR = 32'h1FFF_FFFF;
  localparam logic [WORD_W-1:0] ADDR_MASK = 32'hFFFF_FFFC;
  localparam logic [WORD_W-1:0] RETURN_CODE = 32'h0002_0000;
  localparam logic [WORD_W-1:0] HEADER_MASK = 32'hE003_0003;
  localparam logic [WORD_W-1:0] HEADER_INC = 32'h0000_0000;
  localparam logic [WORD_W-1:0] HEADER_NONINC = 32'h4000_0000;
  localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

  localparam logic [1:0] TAG_JUMP = 2'd1;
  localparam logic [1:0] TAG_CALL = 2'd2;

  typedef struct packed {
    logic operation;
    logic [CHANNEL_W-1:0] channel;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic fetch_valid;
    logic [WORD_W-1:0] fetch_address;
    logic [WORD_W-1:0] get_pointer;
    logic method_valid;
    logic is_bind;
    logic [SUBCH_W-1:0] subchannel;
    logic [MADDR_W-1:0] method_address;
    logic [WORD_W-1:0] method_data;
    logic [ERR_W-1:0] error_code;
  } res_t;

  typedef struct packed {
    logic [WORD_W-1:0] get_ptr;
    logic [WORD_W-1:0] put_ptr;
    logic [INDEX_W-1:0] method_index;
    logic [SUBCH_W-1:0] active_subchannel;
    logic [COUNT_W-1:0] remaining_count;
    logic non_increasing;
    logic in_subroutine;
    logic [WORD_W-1:0] return_address;
  } chan_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/pbcd_cmd_if.sv
// ----------------------------------------------------------------------------
// pbcd_cmd_if
// Input channel: submit and deliver beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbcd_cmd_if;
  logic valid;
  logic ready;
  pbcd_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pbcd_res_if.sv
// ----------------------------------------------------------------------------
// pbcd_res_if
// Result channel: one status beat per input beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbcd_res_if;
  logic valid;
  logic ready;
  pbcd_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pbcd_decode.sv
// ----------------------------------------------------------------------------
// pbcd_decode
// Decodes one beat against one channel's state: next state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcd_decode (
  input  wire logic                        operation,
  input  wire logic [pbcd_pkg::WORD_W-1:0] value,
  input  wire logic [pbcd_pkg::WORD_W-1:0] buffer_base,
  input  wire logic [pbcd_pkg::WORD_W-1:0] buffer_limit,
  input  wire pbcd_pkg::chan_state_t       cur,
  output pbcd_pkg::chan_state_t            nxt,
  output pbcd_pkg::res_t                   res
);

  logic [pbcd_pkg::WORD_W-1:0] step_ptr;
  logic [pbcd_pkg::WORD_W-1:0] g;
  logic [pbcd_pkg::ERR_W-1:0] err;
  logic idle;
  logic can_fetch;

  assign step_ptr = cur.get_ptr + pbcd_pkg::WORD_STEP;
  assign can_fetch = (cur.get_ptr != cur.put_ptr) && (cur.get_ptr < buffer_limit);

  always_comb begin
    nxt = cur;
    err = pbcd_pkg::ERR_NONE;
    idle = 1'b0;
    res = '0;
    g = step_ptr;

    if (operation == pbcd_pkg::OP_SUBMIT) begin
      if (value == '0) begin
        idle = 1'b1;
      end else begin
        nxt.put_ptr = value;
      end
    end else if (can_fetch) begin
      if (cur.remaining_count != '0) begin
        res.method_valid = 1'b1;
        res.is_bind = (cur.method_index == '0);
        res.subchannel = cur.active_subchannel;
        res.method_address = {cur.method_index, 2'b00};
        res.method_data = value;
        if (!cur.non_increasing) begin
          nxt.method_index = cur.method_index + 1'b1;
        end
        nxt.remaining_count = cur.remaining_count - 1'b1;
      end else if ((value & pbcd_pkg::OLD_JUMP_MASK) == pbcd_pkg::OLD_JUMP_CODE) begin
        g = value & pbcd_pkg::OLD_JUMP_ADDR;
      end else if (value[1:0] == pbcd_pkg::TAG_JUMP) begin
        g = value & pbcd_pkg::ADDR_MASK;
      end else if (value[1:0] == pbcd_pkg::TAG_CALL) begin
        if (cur.in_subroutine) begin
          err = pbcd_pkg::ERR_NEST;
        end else begin
          nxt.return_address = step_ptr & pbcd_pkg::ADDR_MASK;
          nxt.in_subroutine = 1'b1;
          g = value & pbcd_pkg::ADDR_MASK;
        end
      end else if (value == pbcd_pkg::RETURN_CODE) begin
        if (!cur.in_subroutine) begin
          err = pbcd_pkg::ERR_RET;
        end else begin
          g = cur.return_address & pbcd_pkg::ADDR_MASK;
          nxt.return_address = '0;
          nxt.in_subroutine = 1'b0;
        end
      end else if ((value & pbcd_pkg::HEADER_MASK) == pbcd_pkg::HEADER_INC ||
                   (value & pbcd_pkg::HEADER_MASK) == pbcd_pkg::HEADER_NONINC) begin
        nxt.method_index = value[12:2];
        nxt.active_subchannel = value[15:13];
        nxt.remaining_count = value[28:18];
        nxt.non_increasing = value[30];
      end else begin
        err = pbcd_pkg::ERR_CMD;
      end
      nxt.get_ptr = g;
    end

    if (err == pbcd_pkg::ERR_NONE && !idle && nxt.get_ptr != nxt.put_ptr) begin
      if (nxt.get_ptr >= buffer_limit) begin
        err = pbcd_pkg::ERR_MEM;
      end else begin
        res.fetch_valid = 1'b1;
      end
    end
    res.fetch_address = buffer_base + nxt.get_ptr;
    res.get_pointer = nxt.get_ptr;
    res.error_code = err;
  end

endmodule

`default_nettype wire

FILE: rtl/core/pushbuffer_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// pushbuffer_command_decoder_unit
// Per-channel pushbuffer command decoder with registered input and result.
// ----------------------------------------------------------------------------
// Every beat on cmd (a put pointer submit or a fetched word for one channel)
// produces exactly one status beat on res, through the input and result
// registers. A new beat is taken every cycle: the input register feeds the
// channel state read, decode and state write-back in the same cycle, so beats
// for the same channel may follow back to back. Throughput drops below one beat
// per cycle only while res holds ready low. The user must write buffer_base and
// buffer_limit through the cfg port while no beat is in flight; not enforced.
`default_nettype none

module pushbuffer_command_decoder_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  pbcd_cmd_if.sink                              cmd,
  pbcd_res_if.source                            res,
  input  wire logic                             cfg_write,
  input  wire logic [pbcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pbcd_pkg::WORD_W-1:0]      cfg_data
);

  logic [pbcd_pkg::WORD_W-1:0] buffer_base;
  logic [pbcd_pkg::WORD_W-1:0] buffer_limit;

  pbcd_pkg::chan_state_t state [pbcd_pkg::CHANNELS];

  logic stage_valid;
  pbcd_pkg::cmd_t stage;

  logic out_valid;
  pbcd_pkg::res_t out_data;

  logic advance;
  logic channel_ok;
  pbcd_pkg::chan_state_t cur;
  pbcd_pkg::chan_state_t nxt;
  pbcd_pkg::res_t res_next;

  assign advance = stage_valid && (!out_valid || res.ready);
  assign cmd.ready = !stage_valid || advance;
  assign channel_ok = int'(stage.channel) < pbcd_pkg::CHANNELS;
  assign cur = channel_ok ? state[stage.channel] : '0;

  pbcd_decode u_decode (
    .operation    (stage.operation),
    .value        (stage.value),
    .buffer_base  (buffer_base),
    .buffer_limit (buffer_limit),
    .cur          (cur),
    .nxt          (nxt),
    .res          (res_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= pbcd_pkg::BUFFER_BASE_RESET;
      buffer_limit <= pbcd_pkg::BUFFER_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pbcd_pkg::REG_BUFFER_BASE: buffer_base <= cfg_data;
        pbcd_pkg::REG_BUFFER_LIMIT: buffer_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      stage <= cmd.payload;
    end
  end

  // channel state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pbcd_pkg::CHANNELS; i++) begin
        state[i] <= '0;
      end
    end else if (advance && channel_ok) begin
      state[stage.channel] <= nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= channel_ok ? res_next : '0;
    end
  end

  assign res.valid = out_valid;
  assign res.payload = out_data;

endmodule

`default_nettype wire

FILE: dv/tb_pushbuffer_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_pushbuffer_command_decoder_unit
// Self-checking bench for the per-channel pushbuffer command decoder. A
// directed opening walks through headers, method runs, binds, jumps, calls,
// returns and every error code. Random bursts of submits and fetched words
// follow, spread over several buffer base and limit settings. Each accepted
// command beat is decoded by an in-bench channel model, and every status
// beat is compared in order against it.
// ----------------------------------------------------------------------------
module tb_pushbuffer_command_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pbcd_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  logic drv_valid = 1'b0;
  cmd_t drv_beat = '0;
  logic rcv_ready = 1'b0;
  logic beat_taken = 1'b0;

  pbcd_cmd_if cmd_bus ();
  pbcd_res_if res_bus ();

  assign cmd_bus.valid = drv_valid;
  assign cmd_bus.payload = drv_beat;
  assign res_bus.ready = rcv_ready;

  pushbuffer_command_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .res(res_bus),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  chan_state_t chan_st [CHANNELS];
  logic [WORD_W-1:0] base_reg;
  logic [WORD_W-1:0] limit_reg;

  cmd_t beat_q [$];
  res_t status_q [$];
  res_t want;
  int bad_beats = 0;
  int idle_pct = 8;
  int stall_pct = 8;

  int seq_left [CHANNELS];
  int seq_kind [CHANNELS];
  logic seq_head [CHANNELS];

  // channel model: one status per command beat
  function automatic res_t decode_beat(cmd_t beat);
    res_t r;
    chan_state_t s;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] nxt;
    logic [ERR_W-1:0] err;
    logic poke;
    r = '0;
    s = chan_st[beat.channel];
    w = beat.value;
    err = ERR_NONE;
    poke = 1'b0;
    if (beat.operation == OP_SUBMIT) begin
      if (w == '0) poke = 1'b1;
      else s.put_ptr = w;
    end else if (s.get_ptr != s.put_ptr && s.get_ptr < limit_reg) begin
      nxt = s.get_ptr + WORD_STEP;
      if (s.remaining_count != '0) begin
        r.method_valid = 1'b1;
        r.is_bind = (s.method_index == '0);
        r.subchannel = s.active_subchannel;
        r.method_address = {s.method_index, 2'b00};
        r.method_data = w;
        if (!s.non_increasing) s.method_index = s.method_index + 1'b1;
        s.remaining_count = s.remaining_count - 1'b1;
      end else if ((w & OLD_JUMP_MASK) == OLD_JUMP_CODE) begin
        nxt = w & OLD_JUMP_ADDR;
      end else if (w[1:0] == TAG_JUMP) begin
        nxt = w & ADDR_MASK;
      end else if (w[1:0] == TAG_CALL) begin
        if (s.in_subroutine) begin
          err = ERR_NEST;
        end else begin
          s.return_address = nxt & ADDR_MASK;
          s.in_subroutine = 1'b1;
          nxt = w & ADDR_MASK;
        end
      end else if (w == RETURN_CODE) begin
        if (!s.in_subroutine) begin
          err = ERR_RET;
        end else begin
          nxt = s.return_address & ADDR_MASK;
          s.return_address = '0;
          s.in_subroutine = 1'b0;
        end
      end else if ((w & HEADER_MASK) == HEADER_INC ||
                   (w & HEADER_MASK) == HEADER_NONINC) begin
        s.method_index = w[12:2];
        s.active_subchannel = w[15:13];
        s.remaining_count = w[28:18];
        s.non_increasing = ((w & HEADER_MASK) == HEADER_NONINC);
      end else begin
        err = ERR_CMD;
      end
      s.get_ptr = nxt;
    end
    if (err == ERR_NONE && !poke && s.get_ptr != s.put_ptr) begin
      if (s.get_ptr >= limit_reg) err = ERR_MEM;
      else r.fetch_valid = 1'b1;
    end
    r.fetch_address = base_reg + s.get_ptr;
    r.get_pointer = s.get_ptr;
    r.error_code = err;
    chan_st[beat.channel] = s;
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("fv=%0b fa=%h gp=%h mv=%0b bind=%0b sc=%0d ma=%h md=%h err=%0d",
                     r.fetch_valid, r.fetch_address, r.get_pointer, r.method_valid,
                     r.is_bind, r.subchannel, r.method_address, r.method_data,
                     r.error_code);
  endfunction

  function automatic logic [WORD_W-1:0] header_word(logic noninc, logic [COUNT_W-1:0] count,
                                                     logic [SUBCH_W-1:0] subch,
                                                     logic [INDEX_W-1:0] method);
    return (noninc ? HEADER_NONINC : HEADER_INC) | {3'b000, count, 2'b00, subch, method, 2'b00};
  endfunction

  function automatic logic [WORD_W-1:0] random_header(logic noninc);
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] method;
    count = COUNT_W'(($urandom_range(99) < 98) ? $urandom_range(6) : $urandom_range(2047));
    case ($urandom_range(3))
      0: method = '0;
      1: method = '1;
      default: method = INDEX_W'($urandom);
    endcase
    return header_word(noninc, count, SUBCH_W'($urandom), method);
  endfunction

  // mostly inside the valid window, now and then anywhere
  function automatic logic [WORD_W-1:0] pick_target();
    logic [WORD_W-1:0] span;
    span = (limit_reg < 32'h1000) ? limit_reg : 32'h1000;
    if (span == '0 || $urandom_range(99) < 4) return $urandom & ADDR_MASK;
    return $urandom_range(span - 1, 0) & ADDR_MASK;
  endfunction

  function automatic logic [WORD_W-1:0] random_word(logic control);
    logic [WORD_W-1:0] t;
    t = pick_target();
    case ($urandom_range(control ? 14 : 8))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: return random_header(1'b0);
      7: return random_header(1'b1);
      8: return $urandom | 32'hE000_0003;  // tag 3 with top bits set: invalid
      9, 13: return RETURN_CODE;
      10: return OLD_JUMP_CODE | (t & OLD_JUMP_ADDR);
      11: return t | TAG_JUMP;
      12: return t | TAG_CALL;
      default: return $urandom;
    endcase
  endfunction

  // kinds 0-4: run up to put, 5-7: control flow, 8: noise, 9: put updates
  function automatic cmd_t next_beat(int c);
    cmd_t b;
    b.channel = CHANNEL_W'(c);
    b.operation = OP_DELIVER;
    b.value = '0;
    if (seq_head[c] && seq_kind[c] < 8) begin
      b.operation = OP_SUBMIT;
      if (seq_kind[c] < 5)
        b.value = chan_st[c].get_ptr + WORD_STEP * (seq_left[c] - 2);
      else
        b.value = pick_target();
    end else if (seq_kind[c] < 5) begin
      b.value = random_word(1'b0);
    end else if (seq_kind[c] < 8) begin
      b.value = random_word(1'b1);
    end else if (seq_kind[c] == 8) begin
      b.operation = 1'($urandom_range(1));
      b.value = ($urandom_range(3) == 0) ? '0 : $urandom;
    end else begin
      b.operation = OP_SUBMIT;
      b.value = ($urandom_range(3) == 0) ? '0 : pick_target();
    end
    seq_head[c] = 1'b0;
    return b;
  endfunction

  task automatic add_beat(input logic op, input int ch, input logic [WORD_W-1:0] v);
    cmd_t b;
    b.operation = op;
    b.channel = CHANNEL_W'(ch);
    b.value = v;
    beat_q.push_back(b);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (beat_q.size() != 0 || drv_valid || status_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_BUFFER_BASE: base_reg = data;
      REG_BUFFER_LIMIT: limit_reg = data;
      default: ;
    endcase
  endtask

  task automatic fill_burst(inout int added);
    int c;
    int live;
    live = 0;
    for (c = 0; c < CHANNELS; c++) begin
      seq_left[c] = 0;
      if ($urandom_range(2) == 0) begin
        seq_kind[c] = $urandom_range(9);
        seq_head[c] = 1'b1;
        seq_left[c] = (seq_kind[c] < 5) ? $urandom_range(1, 10) + 2 : $urandom_range(2, 12);
        live += seq_left[c];
      end
    end
    while (live > 0) begin
      c = $urandom_range(CHANNELS - 1);
      if (seq_left[c] > 0) begin
        beat_q.push_back(next_beat(c));
        seq_left[c]--;
        live--;
        added++;
      end
    end
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] limit,
                           input int beats, input int idle);
    int added;
    write_reg(REG_BUFFER_BASE, base);
    write_reg(REG_BUFFER_LIMIT, limit);
    idle_pct = idle;
    stall_pct = idle;
    added = 0;
    while (added < beats) begin
      fill_burst(added);
      wait_drained();
    end
  endtask

  // command driver and result receiver
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || beat_taken) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_beat <= beat_q.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
    rcv_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // monitor: predict on each command beat, check each status beat
  always @(posedge clk) begin
    beat_taken <= !rst && cmd_bus.valid && cmd_bus.ready;
    if (!rst && cmd_bus.valid && cmd_bus.ready)
      status_q.push_back(decode_beat(cmd_bus.payload));
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (status_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t: status beat with none pending: %s", $time, show(res_bus.payload));
      end else begin
        want = status_q.pop_front();
        if (res_bus.payload !== want) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("%0t: status mismatch", $time);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(res_bus.payload));
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_BUFFER_BASE;
    cfg_data = '0;
    base_reg = BUFFER_BASE_RESET;
    limit_reg = BUFFER_LIMIT_RESET;
    for (int c = 0; c < CHANNELS; c++) chan_st[c] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_beat(OP_DELIVER, 0, 32'hFFFF_FFFF);
    add_beat(OP_SUBMIT, 1, 32'h0);
    add_beat(OP_SUBMIT, 7, 32'hFFFF_FFFF);
    add_beat(OP_SUBMIT, 0, 32'hFFFF_FFFC);
    add_beat(OP_DELIVER, 0, header_word(1'b0, 11'd3, 3'd7, 11'h7FF));
    add_beat(OP_DELIVER, 0, 32'hFFFF_FFFF);
    add_beat(OP_DELIVER, 0, 32'h0000_0002);
    add_beat(OP_DELIVER, 0, OLD_JUMP_CODE);
    add_beat(OP_DELIVER, 0, header_word(1'b1, 11'd2, 3'd5, 11'h0));
    add_beat(OP_DELIVER, 0, 32'h1234_5678);
    add_beat(OP_DELIVER, 0, RETURN_CODE);
    add_beat(OP_DELIVER, 0, RETURN_CODE);
    add_beat(OP_DELIVER, 0, 32'h100 | TAG_CALL);
    add_beat(OP_DELIVER, 0, 32'h200 | TAG_CALL);
    add_beat(OP_DELIVER, 0, RETURN_CODE);
    add_beat(OP_DELIVER, 0, 32'hE000_0003);
    add_beat(OP_DELIVER, 0, 32'h40 | TAG_JUMP);
    add_beat(OP_DELIVER, 0, header_word(1'b1, 11'd1, 3'd7, 11'h7FF));
    add_beat(OP_DELIVER, 0, 32'h0);
    add_beat(OP_DELIVER, 0, 32'h3FFF_FFFC);
    add_beat(OP_DELIVER, 0, 32'h55);
    add_beat(OP_SUBMIT, 0, 32'h8);
    add_beat(OP_SUBMIT, 2, 32'h8);
    add_beat(OP_DELIVER, 2, 32'h0);
    add_beat(OP_DELIVER, 2, 32'h4);
    add_beat(OP_DELIVER, 2, 32'h1);
    wait_drained();

    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 500, 8);
    run_phase($urandom, 32'h0000_2000, 400, 0);
    run_phase(32'h8000_0000, 32'h0, 100, 8);
    run_phase(32'h0, BUFFER_LIMIT_RESET, 500, 8);
    run_phase($urandom, $urandom_range(32'hFFFF, 32'h100), 400, 8);

    repeat (8) @(posedge clk);
    if (bad_beats == 0 && status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
